[sv/escaped_string_decoder_unit_defines.svh]
// Assertion macros used by the checker file of the escaped string decoder.
// Depends on: clk and arst_n being visible where the macros are used.
`ifndef ESCAPED_STRING_DECODER_UNIT_DEFINES_SVH
`define ESCAPED_STRING_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define ESD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/esd_pkg.sv]
// Package for the escaped string decoder: item types, phase and status codes,
// character constants and the small decode functions. Depends on nothing.
`default_nettype none

package esd_pkg;

	typedef enum logic [8:0] {
		PH_FIRST = 9'b000000001,
		PH_PASS  = 9'b000000010,
		PH_BODY  = 9'b000000100,
		PH_ESC   = 9'b000001000,
		PH_HEX1  = 9'b000010000,
		PH_HEX2  = 9'b000100000,
		PH_OCT2  = 9'b001000000,
		PH_OCT3  = 9'b010000000,
		PH_DONE  = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ERR     = 2'd1,
		ST_PENDING = 2'd2
	} status_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       done_res;
		logic [1:0] status;
	} res_item_t;

	// {hit, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b inside {[8'h30:8'h39]})      r = {1'b1, b[3:0]};
		else if (b inside {[8'h41:8'h46]}) r = {1'b1, b[3:0] + 4'd9};
		else if (b inside {[8'h61:8'h66]}) r = {1'b1, b[3:0] + 4'd9};
		return r;
	endfunction

	// {hit, decoded byte}
	function automatic logic [8:0] letter_escape(input logic [7:0] b);
		logic [8:0] r;
		r = 9'd0;
		case (b)
			8'h30: r = {1'b1, 8'd0};
			8'h6E: r = {1'b1, 8'd10};
			8'h72: r = {1'b1, 8'd13};
			8'h74: r = {1'b1, 8'd9};
			8'h76: r = {1'b1, 8'd11};
			8'h61: r = {1'b1, 8'd7};
			8'h62: r = {1'b1, 8'd8};
			8'h66: r = {1'b1, 8'd12};
			8'h27: r = {1'b1, 8'd39};
			8'h22: r = {1'b1, 8'd34};
			8'h5C: r = {1'b1, 8'd92};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/esd_ifs.sv]
// Valid/ready channel interfaces for raw text bytes and decoded results.
// Depends on: nothing.
`default_nettype none

interface esd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       is_last;

	modport source (output valid, byte_in, is_last, input ready);
	modport sink   (input valid, byte_in, is_last, output ready);
endinterface

interface esd_out_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, out_valid, out_byte, done_res, status, input ready);
	modport sink   (input valid, out_valid, out_byte, done_res, status, output ready);
endinterface

`default_nettype wire

[sv/esd_in_stage.sv]
// Input register stage of the escaped string decoder.
// Depends on: esd_pkg.
`default_nettype none

module esd_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  esd_pkg::in_item_t     in_item,
	input  wire logic             take,
	output logic                  valid_s1,
	output esd_pkg::in_item_t     item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

[sv/esd_decode.sv]
// Escape decoder: phase, digit accumulator and held status, plus the
// per-byte decode logic. Depends on: esd_pkg.
`default_nettype none

module esd_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  esd_pkg::in_item_t  item,
	output esd_pkg::res_item_t res
);

	esd_pkg::phase_t  phase_q, phase_n;
	logic [5:0]       acc_q, acc_n;
	esd_pkg::status_t fstat_q, fstat_n;

	logic [7:0] b;
	logic       last;
	logic [4:0] hv;
	logic [8:0] lv;
	logic [8:0] oct_val;
	logic       err, ok_end;
	logic       r_valid, r_done;
	logic [7:0] r_byte;
	esd_pkg::status_t r_st;

	assign b       = item.byte_in;
	assign last    = item.is_last;
	assign hv      = esd_pkg::hex_value(b);
	assign lv      = esd_pkg::letter_escape(b);
	assign oct_val = {acc_q, b[2:0]};

	always_comb begin
		r_valid = 1'b0;
		r_byte  = 8'd0;
		r_done  = 1'b0;
		r_st    = esd_pkg::ST_PENDING;
		err     = 1'b0;
		ok_end  = 1'b0;
		phase_n = phase_q;
		acc_n   = acc_q;
		fstat_n = fstat_q;
		case (phase_q)
			esd_pkg::PH_PASS: begin
				r_valid = 1'b1;
				r_byte  = b;
				r_done  = 1'b1;
				r_st    = esd_pkg::ST_OK;
			end
			esd_pkg::PH_BODY: begin
				if (b == esd_pkg::CH_QUOTE) begin
					ok_end = 1'b1;
				end else if (b == esd_pkg::CH_BSL) begin
					phase_n = esd_pkg::PH_ESC;
				end else begin
					r_valid = 1'b1;
					r_byte  = b;
				end
			end
			esd_pkg::PH_ESC: begin
				if (lv[8]) begin
					r_valid = 1'b1;
					r_byte  = lv[7:0];
					phase_n = esd_pkg::PH_BODY;
				end else if (b == esd_pkg::CH_X) begin
					phase_n = esd_pkg::PH_HEX1;
				end else if (b inside {[esd_pkg::CH_ONE:esd_pkg::CH_SEVEN]}) begin
					acc_n   = {3'd0, b[2:0]};
					phase_n = esd_pkg::PH_OCT2;
				end else begin
					err = 1'b1;
				end
			end
			esd_pkg::PH_HEX1: begin
				if (hv[4]) begin
					acc_n   = {2'd0, hv[3:0]};
					phase_n = esd_pkg::PH_HEX2;
				end else begin
					err = 1'b1;
				end
			end
			esd_pkg::PH_HEX2: begin
				if (hv[4]) begin
					r_valid = 1'b1;
					r_byte  = {acc_q[3:0], hv[3:0]};
					phase_n = esd_pkg::PH_BODY;
				end else begin
					err = 1'b1;
				end
			end
			esd_pkg::PH_OCT2: begin
				if (b inside {[esd_pkg::CH_ZERO:esd_pkg::CH_SEVEN]}) begin
					acc_n   = {acc_q[2:0], b[2:0]};
					phase_n = esd_pkg::PH_OCT3;
				end else begin
					err = 1'b1;
				end
			end
			esd_pkg::PH_OCT3: begin
				if (!(b inside {[esd_pkg::CH_ZERO:esd_pkg::CH_SEVEN]}) || oct_val[8]) begin
					err = 1'b1;
				end else begin
					r_valid = 1'b1;
					r_byte  = oct_val[7:0];
					phase_n = esd_pkg::PH_BODY;
				end
			end
			esd_pkg::PH_DONE: begin
				r_done = 1'b1;
				r_st   = fstat_q;
			end
			default: begin
				if (b == esd_pkg::CH_QUOTE) begin
					phase_n = esd_pkg::PH_BODY;
				end else begin
					r_valid = 1'b1;
					r_byte  = b;
					r_done  = 1'b1;
					r_st    = esd_pkg::ST_OK;
					phase_n = esd_pkg::PH_PASS;
					fstat_n = esd_pkg::ST_OK;
				end
			end
		endcase

		// unterminated string
		if (!err && !ok_end && !r_done && last) begin
			err = 1'b1;
		end

		if (err || ok_end) begin
			r_st    = err ? esd_pkg::ST_ERR : esd_pkg::ST_OK;
			r_done  = 1'b1;
			fstat_n = r_st;
			phase_n = esd_pkg::PH_DONE;
			acc_n   = 6'd0;
		end

		if (last) begin
			phase_n = esd_pkg::PH_FIRST;
			acc_n   = 6'd0;
			fstat_n = esd_pkg::ST_PENDING;
		end
	end

	assign res.out_valid = r_valid;
	assign res.out_byte  = r_byte;
	assign res.done_res  = r_done;
	assign res.status    = r_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= esd_pkg::PH_FIRST;
			acc_q   <= 6'd0;
			fstat_q <= esd_pkg::ST_PENDING;
		end else if (fire) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			fstat_q <= fstat_n;
		end
	end

endmodule

`default_nettype wire

[sv/esd_out_stage.sv]
// Result register stage of the escaped string decoder.
// Depends on: esd_pkg.
`default_nettype none

module esd_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s1,
	input  esd_pkg::res_item_t  res,
	output logic                take,
	output logic                valid_s2,
	output esd_pkg::res_item_t  res_s2,
	input  wire logic           out_ready
);

	assign take = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

[sv/escaped_string_decoder_unit.sv]
// Top level of the escaped string decoder: input register, decode, result register.
// Depends on: esd_pkg, esd_ifs, esd_in_stage, esd_decode, esd_out_stage.
//
//   channel   modport        payload                                  rate
//   text      esd_in_if      byte_in[7:0], is_last                    1 item/cycle
//   decoded   esd_out_if     out_valid, out_byte[7:0], done_res,      1 item/cycle
//                            status[1:0]
//
// A result shows on decoded once its item has passed from the input register
// through the decode into the result register.
// One result per text item; items stream back to back at one per cycle while decoded is not stalled.
// The decode state (phase, digit accumulator, held status) steps when an item
// moves from the input register into the result register.
// Reset clears the phase to first character and empties both registers.
// A stall on decoded holds the result register; text.ready drops in the same
// cycle once the input register is full as well.
`default_nettype none

module escaped_string_decoder_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	esd_in_if.sink     text,
	esd_out_if.source  decoded
);

	esd_pkg::in_item_t  in_item, item_s1;
	esd_pkg::res_item_t res, res_s2;
	logic               valid_s1, valid_s2, take;

	assign in_item.byte_in = text.byte_in;
	assign in_item.is_last = text.is_last;

	esd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	esd_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && take),
		.item   (item_s1),
		.res    (res)
	);

	esd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.take      (take),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2),
		.out_ready (decoded.ready)
	);

	assign decoded.valid     = valid_s2;
	assign decoded.out_valid = res_s2.out_valid;
	assign decoded.out_byte  = res_s2.out_byte;
	assign decoded.done_res  = res_s2.done_res;
	assign decoded.status    = res_s2.status;

endmodule

`default_nettype wire

[sv/esd_checker.sv]
// Port-level checks for the escaped string decoder, bound to the top level.
// Depends on: esd_pkg, escaped_string_decoder_unit_defines.svh.
`default_nettype none
`include "escaped_string_decoder_unit_defines.svh"

module esd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       o_vld,
	input wire logic       o_rdy,
	input wire logic       o_out_valid,
	input wire logic [7:0] o_out_byte,
	input wire logic       o_done,
	input wire logic [1:0] o_status
);

	`ESD_ASSERT_NXT(a_stall_hold, o_vld && !o_rdy, o_vld && $stable(o_out_byte) && $stable(o_status) && $stable(o_done) && $stable(o_out_valid), "decoded item changed while stalled")
	`ESD_ASSERT_IMP(a_done_status, o_vld, o_done == (o_status != esd_pkg::ST_PENDING), "done_res and status disagree")
	`ESD_ASSERT_IMP(a_idle_byte, o_vld && !o_out_valid, o_out_byte == 8'd0, "byte set without out_valid")
	`ESD_ASSERT_IMP(a_status_code, o_vld, o_status == esd_pkg::ST_OK || o_status == esd_pkg::ST_ERR || o_status == esd_pkg::ST_PENDING, "unknown status code")

endmodule

bind escaped_string_decoder_unit esd_checker u_esd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.o_vld       (decoded.valid),
	.o_rdy       (decoded.ready),
	.o_out_valid (decoded.out_valid),
	.o_out_byte  (decoded.out_byte),
	.o_done      (decoded.done_res),
	.o_status    (decoded.status)
);

`default_nettype wire

[verif/tb_escaped_string_decoder_unit.sv]
// Testbench for escaped_string_decoder_unit: drives raw value text, a directed table then
// random values, and checks every result against the typed row or a cycle-free predictor.
// Depends on: esd_pkg, esd_ifs and the RTL of escaped_string_decoder_unit.
`timescale 1ns / 1ps

module tb_escaped_string_decoder_unit;
	import esd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int MAX_REPORTS = 10;
	localparam res_item_t R_IDLE = '{1'b0, 8'h00, 1'b0, ST_PENDING};
	localparam logic [7:0] ESC_LETTERS [11] = '{8'h30, 8'h6E, 8'h72, 8'h74, 8'h76, 8'h61,
		8'h62, 8'h66, 8'h27, CH_QUOTE, CH_BSL};

	typedef struct {
		logic [7:0] ch;
		logic       last;
		bit         typed;
		res_item_t  want;
	} text_row_t;

	logic clk;
	logic arst_n;

	esd_in_if  text_ch ();
	esd_out_if dec_ch ();

	escaped_string_decoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.decoded (dec_ch)
	);

	// predictor state
	phase_t     dec_phase;
	logic [8:0] dec_acc;
	status_t    held_status;

	res_item_t  decoded_q [$];
	logic [7:0] value_q [$];
	int         mismatches;
	int         quiet_cycles;
	int         idle_pct;
	bit         row_typed;
	res_item_t  row_want;
	text_row_t  dir_rows [25];

	always #5 clk = ~clk;

	function automatic int hex_nibble(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
		if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
		if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
		return -1;
	endfunction

	function automatic res_item_t decode_char(input logic [7:0] b, input logic last);
		res_item_t  r;
		logic       bad;
		logic       closed;
		int         nib;
		logic [8:0] oct_val;
		r = R_IDLE;
		bad = 1'b0;
		closed = 1'b0;
		nib = hex_nibble(b);
		oct_val = {dec_acc[5:0], b[2:0]};
		case (dec_phase)
			PH_PASS: r = '{1'b1, b, 1'b1, ST_OK};
			PH_BODY: begin
				if (b == CH_QUOTE) closed = 1'b1;
				else if (b == CH_BSL) dec_phase = PH_ESC;
				else begin
					r.out_valid = 1'b1;
					r.out_byte = b;
				end
			end
			PH_ESC: begin
				dec_phase = PH_BODY;
				r.out_valid = 1'b1;
				case (b)
					CH_ZERO:  r.out_byte = 8'd0;
					8'h6E:    r.out_byte = 8'd10;
					8'h72:    r.out_byte = 8'd13;
					8'h74:    r.out_byte = 8'd9;
					8'h76:    r.out_byte = 8'd11;
					8'h61:    r.out_byte = 8'd7;
					8'h62:    r.out_byte = 8'd8;
					8'h66:    r.out_byte = 8'd12;
					8'h27:    r.out_byte = 8'd39;
					CH_QUOTE: r.out_byte = 8'd34;
					CH_BSL:   r.out_byte = 8'd92;
					default: begin
						r.out_valid = 1'b0;
						if (b == CH_X) dec_phase = PH_HEX1;
						else if (b >= CH_ONE && b <= CH_SEVEN) begin
							dec_acc = {6'd0, b[2:0]};
							dec_phase = PH_OCT2;
						end else bad = 1'b1;
					end
				endcase
			end
			PH_HEX1: begin
				if (nib < 0) bad = 1'b1;
				else begin
					dec_acc = 9'(nib);
					dec_phase = PH_HEX2;
				end
			end
			PH_HEX2: begin
				if (nib < 0) bad = 1'b1;
				else begin
					r.out_valid = 1'b1;
					r.out_byte = {dec_acc[3:0], 4'(nib)};
					dec_phase = PH_BODY;
				end
			end
			PH_OCT2: begin
				if (b < CH_ZERO || b > CH_SEVEN) bad = 1'b1;
				else begin
					dec_acc = oct_val;
					dec_phase = PH_OCT3;
				end
			end
			PH_OCT3: begin
				if (b < CH_ZERO || b > CH_SEVEN || oct_val > 9'd255) bad = 1'b1;
				else begin
					r.out_valid = 1'b1;
					r.out_byte = oct_val[7:0];
					dec_phase = PH_BODY;
				end
			end
			PH_DONE: begin
				r.done_res = 1'b1;
				r.status = held_status;
			end
			default: begin
				if (b == CH_QUOTE) dec_phase = PH_BODY;
				else begin
					r = '{1'b1, b, 1'b1, ST_OK};
					dec_phase = PH_PASS;
					held_status = ST_OK;
				end
			end
		endcase
		// value ended before its closing quote
		if (!bad && !closed && !r.done_res && last) bad = 1'b1;
		if (bad || closed) begin
			r.done_res = 1'b1;
			if (bad) held_status = ST_ERR;
			else held_status = ST_OK;
			r.status = held_status;
			dec_phase = PH_DONE;
			dec_acc = '0;
		end
		if (last) begin
			dec_phase = PH_FIRST;
			dec_acc = '0;
			held_status = ST_PENDING;
		end
		return r;
	endfunction

	function automatic logic [7:0] rand_hex();
		int k;
		k = $urandom_range(21);
		if (k < 10) return 8'(CH_ZERO + k);
		if (k < 16) return 8'(8'h61 + k - 10);
		return 8'(8'h41 + k - 16);
	endfunction

	task automatic add_char(input logic [7:0] c);
		value_q = {value_q, c};
	endtask

	task automatic add_element();
		logic [7:0] c;
		case ($urandom_range(4))
			0, 1: begin
				do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSL);
				add_char(c);
			end
			2: begin
				add_char(CH_BSL);
				add_char(ESC_LETTERS[$urandom_range(10)]);
			end
			3: begin
				add_char(CH_BSL);
				add_char(CH_X);
				add_char(rand_hex());
				add_char(rand_hex());
			end
			default: begin
				add_char(CH_BSL);
				add_char(8'(CH_ONE + $urandom_range(2)));
				add_char(8'(CH_ZERO + $urandom_range(7)));
				add_char(8'(CH_ZERO + $urandom_range(7)));
			end
		endcase
	endtask

	task automatic add_fault();
		logic [7:0] c;
		bit         known;
		add_char(CH_BSL);
		case ($urandom_range(3))
			0: begin
				// unknown escape letter
				do begin
					c = 8'($urandom);
					known = (c == CH_X) || (c >= CH_ONE && c <= CH_SEVEN);
					foreach (ESC_LETTERS[i]) if (c == ESC_LETTERS[i]) known = 1'b1;
				end while (known);
				add_char(c);
			end
			1: begin
				add_char(CH_X);
				if ($urandom_range(1)) add_char(rand_hex());
				do c = 8'($urandom); while (hex_nibble(c) >= 0);
				add_char(c);
			end
			2: begin
				add_char(8'(CH_ONE + $urandom_range(6)));
				if ($urandom_range(1)) add_char(8'(CH_ZERO + $urandom_range(7)));
				do c = 8'($urandom); while (c >= CH_ZERO && c <= CH_SEVEN);
				add_char(c);
			end
			default: begin
				// octal above 255
				add_char(8'(CH_ZERO + 4 + $urandom_range(3)));
				add_char(8'(CH_ZERO + $urandom_range(7)));
				add_char(8'(CH_ZERO + $urandom_range(7)));
			end
		endcase
	endtask

	task automatic build_value();
		int         kind;
		logic [7:0] c;
		value_q.delete();
		kind = $urandom_range(99);
		if (kind < 15) begin
			do c = 8'($urandom); while (c == CH_QUOTE);
			add_char(c);
			repeat ($urandom_range(5)) add_char(8'($urandom));
		end else begin
			add_char(CH_QUOTE);
			repeat ($urandom_range(6)) add_element();
			if (kind < 62) add_char(CH_QUOTE);
			else if (kind < 72) begin
				// unterminated, possibly cut inside an escape
				repeat ($urandom_range(2)) if (value_q.size() > 1) void'(value_q.pop_back());
			end else add_fault();
			if (kind < 62 || kind >= 72)
				repeat ($urandom_range(3)) add_char(8'($urandom));
		end
	endtask

	// entered and left just after a falling edge
	task automatic send_char(input logic [7:0] b, input logic last, input bit typed,
			input res_item_t want);
		while ($urandom_range(99) < idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		row_typed = typed;
		row_want = want;
		text_ch.valid <= 1'b1;
		text_ch.byte_in <= b;
		text_ch.is_last <= last;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		dec_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		res_item_t got;
		res_item_t want;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (dec_ch.valid && dec_ch.ready) begin
				moved = 1'b1;
				got = '{dec_ch.out_valid, dec_ch.out_byte, dec_ch.done_res, dec_ch.status};
				if (decoded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: valid=%b byte=%h done=%b status=%0d",
							got.out_valid, got.out_byte, got.done_res, got.status);
				end else begin
					want = decoded_q.pop_front();
					if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
							got.done_res !== want.done_res || got.status !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$write("mismatch: exp valid=%b byte=%h done=%b status=%0d,",
								want.out_valid, want.out_byte, want.done_res, want.status);
							$display(" got valid=%b byte=%h done=%b status=%0d",
								got.out_valid, got.out_byte, got.done_res, got.status);
						end
					end
				end
			end
			if (text_ch.valid && text_ch.ready) begin
				moved = 1'b1;
				want = decode_char(text_ch.byte_in, text_ch.is_last);
				decoded_q = {decoded_q, (row_typed ? row_want : want)};
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(negedge clk);
		$display("tb_escaped_string_decoder_unit: FAIL");
		$finish;
	end

	initial begin
		int rand_items;
		clk = 1'b0;
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.byte_in = 8'h00;
		text_ch.is_last = 1'b0;
		dec_ch.ready = 1'b0;
		dec_phase = PH_FIRST;
		dec_acc = '0;
		held_status = ST_PENDING;
		mismatches = 0;
		quiet_cycles = 0;
		idle_pct = 22;
		row_typed = 1'b0;
		row_want = R_IDLE;
		rand_items = 0;

		dir_rows = '{
			'{8'h41,    1'b0, 1'b1, '{1'b1, 8'h41, 1'b1, ST_OK}},
			'{8'h00,    1'b1, 1'b1, '{1'b1, 8'h00, 1'b1, ST_OK}},
			'{CH_QUOTE, 1'b0, 1'b1, R_IDLE},
			'{CH_BSL,   1'b0, 1'b0, R_IDLE},
			'{CH_X,     1'b0, 1'b0, R_IDLE},
			'{8'h46,    1'b0, 1'b0, R_IDLE},
			'{8'h66,    1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, ST_PENDING}},
			'{CH_BSL,   1'b0, 1'b0, R_IDLE},
			'{8'h33,    1'b0, 1'b0, R_IDLE},
			'{CH_SEVEN, 1'b0, 1'b0, R_IDLE},
			'{CH_SEVEN, 1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, ST_PENDING}},
			'{CH_BSL,   1'b0, 1'b0, R_IDLE},
			'{CH_ZERO,  1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, ST_PENDING}},
			'{8'hFF,    1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, ST_PENDING}},
			'{CH_QUOTE, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, ST_OK}},
			'{8'hFF,    1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, ST_OK}},
			'{CH_QUOTE, 1'b0, 1'b0, R_IDLE},
			'{CH_BSL,   1'b0, 1'b0, R_IDLE},
			'{8'h34,    1'b0, 1'b0, R_IDLE},
			'{CH_ZERO,  1'b0, 1'b0, R_IDLE},
			'{CH_ZERO,  1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, ST_ERR}},
			'{8'hFF,    1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, ST_ERR}},
			'{CH_QUOTE, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, ST_ERR}},
			'{8'hFF,    1'b0, 1'b1, '{1'b1, 8'hFF, 1'b1, ST_OK}},
			'{CH_QUOTE, 1'b1, 1'b1, '{1'b1, CH_QUOTE, 1'b1, ST_OK}}
		};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

		while (rand_items < RANDOM_ITEMS) begin
			idle_pct = (rand_items >= 300 && rand_items < 550) ? 0 : 22;
			build_value();
			foreach (value_q[i])
				send_char(value_q[i], i == value_q.size() - 1, 1'b0, R_IDLE);
			rand_items += value_q.size();
		end
		text_ch.valid <= 1'b0;

		while (decoded_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) $display("tb_escaped_string_decoder_unit: PASS");
		else $display("tb_escaped_string_decoder_unit: FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/esd_pkg.sv
sv/esd_ifs.sv
sv/esd_in_stage.sv
sv/esd_decode.sv
sv/esd_out_stage.sv
sv/escaped_string_decoder_unit.sv
sv/esd_checker.sv
verif/tb_escaped_string_decoder_unit.sv
